>>> hw/rtl/alstep_pkg.sv
`default_nettype none
package alstep_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int WEIGHT_BITS = 9;
  localparam int FW_BITS     = 8;
  localparam logic [WEIGHT_BITS-1:0] FULL_WEIGHT = 9'd256;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/alstep_in_if.sv
`default_nettype none
interface alstep_in_if import alstep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/alstep_out_if.sv
`default_nettype none
interface alstep_out_if import alstep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [COORD_BITS:0]    near_px;
  logic [COORD_BITS:0]    near_py;
  logic [WEIGHT_BITS-1:0] near_weight;
  logic [COORD_BITS:0]    far_px;
  logic [COORD_BITS:0]    far_py;
  logic [WEIGHT_BITS-1:0] far_weight;
  logic                   last_column;

  modport source (output valid, near_px, near_py, near_weight, far_px, far_py, far_weight,
                  last_column, input ready);
  modport sink   (input valid, near_px, near_py, near_weight, far_px, far_py, far_weight,
                  last_column, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/alstep_divider.sv
`default_nettype none
module alstep_divider import alstep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] dividend,
  input  wire logic [COORD_BITS-1:0] divisor,
  output div_status_t                status,
  output logic      [FRAC_BITS:0]    quotient
);

  // restoring division of (dividend << FRAC_BITS) / divisor, dividend <= divisor
  localparam int STEPS = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS:0]   rem;
  logic [COORD_BITS-1:0] dsr;

  logic                  fits;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]   rem_next;

  assign fits     = rem >= {1'b0, dsr};
  assign diff     = fits ? (rem - {1'b0, dsr}) : rem;
  assign rem_next = {diff[COORD_BITS-1:0], 1'b0};

  assign status.busy = busy;
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[FRAC_BITS-1:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/antialiased_line_stepper_core.sv
`default_nettype none
// Anti-aliased line stepper.
// line_in carries items: kind load brings two endpoints, kind step asks for one column.
// column_out carries one column per step while a line is active: a near and a far
// pixel with weights summing to 256, and last_column on the final column.
// A load swaps axes for steep lines, orders the endpoints and starts a one-bit-per-cycle
// restoring divider for the slope. line_in is not ready after a load with distinct
// endpoints until the divider is done and the slope is stored; a zero-length load
// starts no division. Steps stream one per cycle while column_out does not stall; the
// column is registered and shows on column_out the cycle after the step transfer. A
// step with no active line is taken and gives nothing.
// If column_out stalls, the column register holds and line_in drops ready until the
// column transfers.
// Reset (rst, synchronous) leaves the block idle with no active line.
module antialiased_line_stepper_core import alstep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  alstep_in_if.sink   line_in,
  alstep_out_if.source column_out
);

  localparam int ACC_BITS   = COORD_BITS + 1 + FRAC_BITS;
  localparam int SLOPE_BITS = FRAC_BITS + 2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t state;

  logic [COORD_BITS-1:0]        major_pos;
  logic [COORD_BITS-1:0]        major_end;
  logic [ACC_BITS-1:0]          minor_acc;
  logic signed [SLOPE_BITS-1:0] slope_step;
  logic                         axes_swapped;
  logic                         slope_neg;
  logic                         line_active;

  logic                   out_valid;
  logic [COORD_BITS:0]    near_px;
  logic [COORD_BITS:0]    near_py;
  logic [WEIGHT_BITS-1:0] near_weight;
  logic [COORD_BITS:0]    far_px;
  logic [COORD_BITS:0]    far_py;
  logic [WEIGHT_BITS-1:0] far_weight;
  logic                   last_column;

  logic in_ready;
  logic in_xfer;
  logic load_go;
  logic step_go;
  logic div_start;

  logic [COORD_BITS-1:0] adx, ady, maj_d, min_d;
  logic [COORD_BITS-1:0] a1, b1, a2, b2;
  logic [COORD_BITS-1:0] p_major_start, p_major_end, p_minor_start, p_minor_end;
  logic                  steep, rev;

  div_status_t          div_status;
  logic [FRAC_BITS:0]   quotient;
  logic [SLOPE_BITS-1:0] q_ext;

  logic [COORD_BITS:0]  minor, minor_p1, major_ext;
  logic [FW_BITS-1:0]   fw;
  logic                 last;

  assign in_ready      = (state == S_IDLE) && !div_status.busy &&
                         (!out_valid || column_out.ready);
  assign line_in.ready = in_ready;
  assign in_xfer       = line_in.valid && in_ready;
  assign load_go       = in_xfer && (line_in.kind == KIND_LOAD);
  assign step_go       = in_xfer && (line_in.kind == KIND_STEP) && line_active;

  // endpoint setup
  always_comb begin
    adx = (line_in.end_x < line_in.start_x) ? (line_in.start_x - line_in.end_x)
                                            : (line_in.end_x - line_in.start_x);
    ady = (line_in.end_y < line_in.start_y) ? (line_in.start_y - line_in.end_y)
                                            : (line_in.end_y - line_in.start_y);
    steep = adx < ady;
    a1    = steep ? line_in.start_y : line_in.start_x;
    b1    = steep ? line_in.start_x : line_in.start_y;
    a2    = steep ? line_in.end_y   : line_in.end_x;
    b2    = steep ? line_in.end_x   : line_in.end_y;
    maj_d = steep ? ady : adx;
    min_d = steep ? adx : ady;
    rev   = a2 < a1;
    p_major_start = rev ? a2 : a1;
    p_major_end   = rev ? a1 : a2;
    p_minor_start = rev ? b2 : b1;
    p_minor_end   = rev ? b1 : b2;
  end

  assign div_start = load_go && (maj_d != '0);

  alstep_divider #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(min_d),
    .divisor (maj_d),
    .status  (div_status),
    .quotient(quotient)
  );

  assign q_ext = {1'b0, quotient};

  // column
  always_comb begin
    minor     = minor_acc[ACC_BITS-1:FRAC_BITS];
    minor_p1  = minor + (COORD_BITS+1)'(1);
    major_ext = {1'b0, major_pos};
    fw        = minor_acc[FRAC_BITS-1:FRAC_BITS-FW_BITS];
    last      = major_pos >= major_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_active  <= 1'b0;
      major_pos    <= '0;
      major_end    <= '0;
      minor_acc    <= '0;
      slope_step   <= '0;
      axes_swapped <= 1'b0;
      slope_neg    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load_go) begin
            major_pos    <= p_major_start;
            major_end    <= p_major_end;
            minor_acc    <= {1'b0, p_minor_start, {FRAC_BITS{1'b0}}};
            slope_step   <= '0;
            axes_swapped <= steep;
            slope_neg    <= p_minor_end < p_minor_start;
            line_active  <= 1'b1;
            if (div_start) begin
              state <= S_DIV;
            end
          end else if (step_go) begin
            if (last) begin
              line_active <= 1'b0;
            end else begin
              major_pos <= major_pos + COORD_BITS'(1);
              minor_acc <= minor_acc + ACC_BITS'(slope_step);
            end
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            slope_step <= slope_neg ? -$signed(q_ext) : $signed(q_ext);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (column_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      near_px     <= axes_swapped ? minor     : major_ext;
      near_py     <= axes_swapped ? major_ext : minor;
      far_px      <= axes_swapped ? minor_p1  : major_ext;
      far_py      <= axes_swapped ? major_ext : minor_p1;
      near_weight <= FULL_WEIGHT - {1'b0, fw};
      far_weight  <= {1'b0, fw};
      last_column <= last;
    end
  end

  assign column_out.valid       = out_valid;
  assign column_out.near_px     = near_px;
  assign column_out.near_py     = near_py;
  assign column_out.near_weight = near_weight;
  assign column_out.far_px      = far_px;
  assign column_out.far_py      = far_py;
  assign column_out.far_weight  = far_weight;
  assign column_out.last_column = last_column;

endmodule
`default_nettype wire

>>> hw/rtl/alstep_checker.sv
`default_nettype none
module alstep_checker import alstep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   in_kind,
  input wire logic [COORD_BITS-1:0]  start_x,
  input wire logic [COORD_BITS-1:0]  start_y,
  input wire logic [COORD_BITS-1:0]  end_x,
  input wire logic [COORD_BITS-1:0]  end_y,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [WEIGHT_BITS-1:0] near_weight,
  input wire logic [WEIGHT_BITS-1:0] far_weight,
  input wire logic                   last_column
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("column dropped while stalled");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_kind == KIND_LOAD) |=> !out_valid)
    else $error("load produced a column");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_kind == KIND_LOAD) && ((start_x != end_x) || (start_y != end_y))
    |=> !in_ready)
    else $error("ready during slope division");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_column && in_xfer && (in_kind == KIND_STEP)
    |=> !out_valid)
    else $error("column after last column");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, near_weight} + {1'b0, far_weight}) == {1'b0, FULL_WEIGHT})
    else $error("weights do not sum to full");

endmodule

bind antialiased_line_stepper_core alstep_checker #(.COORD_BITS(COORD_BITS)) u_alstep_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (line_in.valid),
  .in_ready   (line_in.ready),
  .in_kind    (line_in.kind),
  .start_x    (line_in.start_x),
  .start_y    (line_in.start_y),
  .end_x      (line_in.end_x),
  .end_y      (line_in.end_y),
  .out_valid  (column_out.valid),
  .out_ready  (column_out.ready),
  .near_weight(column_out.near_weight),
  .far_weight (column_out.far_weight),
  .last_column(column_out.last_column)
);
`default_nettype wire
